// ===== hdl/smf_track_event_parser_top_defines.svh =====
// Assertion macros shared by the track event parser RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef SMF_TRACK_EVENT_PARSER_TOP_DEFINES_SVH
`define SMF_TRACK_EVENT_PARSER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/smf_pkg.sv =====
// Shared types and constants for the track event parser.
// No dependencies; used by every module of the block.
package smf_pkg;

    localparam logic [2:0] MAX_VLQ_BYTES = 3'd4;

    localparam logic [3:0] PH_DELTA      = 4'd0;
    localparam logic [3:0] PH_STATUS     = 4'd1;
    localparam logic [3:0] PH_DATA1      = 4'd2;
    localparam logic [3:0] PH_DATA2      = 4'd3;
    localparam logic [3:0] PH_META_TYPE  = 4'd4;
    localparam logic [3:0] PH_META_LEN   = 4'd5;
    localparam logic [3:0] PH_META_BODY  = 4'd6;
    localparam logic [3:0] PH_SYSEX_LEN  = 4'd7;
    localparam logic [3:0] PH_SYSEX_BODY = 4'd8;

    localparam logic [1:0] KIND_CHANNEL   = 2'd0;
    localparam logic [1:0] KIND_TEMPO     = 2'd1;
    localparam logic [1:0] KIND_END       = 2'd2;
    localparam logic [1:0] KIND_MALFORMED = 2'd3;

    localparam logic [7:0] BYTE_META      = 8'hFF;
    localparam logic [7:0] META_END       = 8'h2F;
    localparam logic [7:0] META_TEMPO     = 8'h51;
    localparam logic [7:0] BYTE_SYSEX     = 8'hF0;
    localparam logic [7:0] BYTE_SYSEX_ESC = 8'hF7;
    localparam logic [3:0] HI_PROGRAM     = 4'hC;
    localparam logic [3:0] HI_PRESSURE    = 4'hD;

    typedef struct packed {
        logic [7:0] track_byte;
        logic       first_of_track;
        logic       last_of_track;
    } item_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [31:0] tick;
        logic [27:0] vlq;
        logic [2:0]  vlq_cnt;
        logic [7:0]  run_status;
        logic [7:0]  cur_status;
        logic [7:0]  held_data;
        logic [7:0]  meta_type;
        logic [27:0] left;
        logic [23:0] tempo;
        logic        ignored;
    } state_t;

    localparam state_t STATE_CLEAR = '0;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [31:0] event_tick;
        logic [7:0]  message_status;
        logic [7:0]  message_data1;
        logic [7:0]  message_data2;
        logic [23:0] tempo_micros;
    } result_t;

endpackage

// ===== hdl/smf_step.sv =====
// Combinational parse step: one track byte against the current parser state.
// Depends on smf_pkg for the state, item and result types.
module smf_step (
    input  smf_pkg::item_t   item_i,
    input  smf_pkg::state_t  state_i,
    output smf_pkg::state_t  state_o,
    output logic             res_vld_o,
    output smf_pkg::result_t res_o
);
    import smf_pkg::*;

    state_t      s;
    state_t      n;
    logic [7:0]  b;
    logic [27:0] vlq_acc;
    logic [27:0] vlq_new;
    logic [2:0]  cnt_inc;
    logic        vlq_done;
    logic        vlq_bad;
    logic [7:0]  mt;
    logic        two_data_cur;
    logic        two_data_run;
    logic        vld;
    logic [1:0]  kind;
    logic [7:0]  r_st;
    logic [7:0]  r_d1;
    logic [7:0]  r_d2;
    logic [23:0] r_tempo;

    always_comb begin
        s = item_i.first_of_track ? STATE_CLEAR : state_i;
        n = s;
        b = item_i.track_byte;
        vld = 1'b0;
        kind = KIND_CHANNEL;
        r_st = '0;
        r_d1 = '0;
        r_d2 = '0;
        r_tempo = '0;
        mt = s.meta_type;

        vlq_acc = (s.vlq_cnt == 3'd0) ? 28'd0 : s.vlq;
        vlq_new = {vlq_acc[20:0], b[6:0]};
        cnt_inc = s.vlq_cnt + 3'd1;
        vlq_done = !b[7];
        vlq_bad = b[7] && (cnt_inc >= MAX_VLQ_BYTES);
        two_data_cur = !(s.cur_status[7:4] == HI_PROGRAM || s.cur_status[7:4] == HI_PRESSURE);
        two_data_run = !(s.run_status[7:4] == HI_PROGRAM || s.run_status[7:4] == HI_PRESSURE);

        if (!s.ignored) begin
            case (s.phase)
                PH_STATUS: begin
                    if (b == BYTE_META) begin
                        n.phase = PH_META_TYPE;
                    end else if (b == BYTE_SYSEX || b == BYTE_SYSEX_ESC) begin
                        n.phase = PH_SYSEX_LEN;
                    end else if (!b[7]) begin
                        if (s.run_status == 8'd0) begin
                            vld = 1'b1;
                            kind = KIND_MALFORMED;
                            n.ignored = 1'b1;
                        end else begin
                            n.cur_status = s.run_status;
                            n.held_data = b;
                            if (two_data_run) begin
                                n.phase = PH_DATA2;
                            end else begin
                                vld = 1'b1;
                                kind = KIND_CHANNEL;
                                r_st = s.run_status;
                                r_d1 = b;
                                n.phase = PH_DELTA;
                            end
                        end
                    end else begin
                        n.run_status = b;
                        n.cur_status = b;
                        n.phase = PH_DATA1;
                    end
                end
                PH_DATA1: begin
                    n.held_data = b;
                    if (two_data_cur) begin
                        n.phase = PH_DATA2;
                    end else begin
                        vld = 1'b1;
                        kind = KIND_CHANNEL;
                        r_st = s.cur_status;
                        r_d1 = b;
                        n.phase = PH_DELTA;
                    end
                end
                PH_DATA2: begin
                    vld = 1'b1;
                    kind = KIND_CHANNEL;
                    r_st = s.cur_status;
                    r_d1 = s.held_data;
                    r_d2 = b;
                    n.phase = PH_DELTA;
                end
                PH_META_TYPE: begin
                    n.meta_type = b;
                    n.tempo = '0;
                    n.phase = PH_META_LEN;
                end
                PH_META_LEN: begin
                    n.vlq = vlq_new;
                    n.vlq_cnt = vlq_done ? 3'd0 : cnt_inc;
                    if (vlq_bad) begin
                        vld = 1'b1;
                        kind = KIND_MALFORMED;
                        n.ignored = 1'b1;
                    end else if (vlq_done) begin
                        if (s.meta_type == META_TEMPO && vlq_new != 28'd3) begin
                            mt = 8'd0;
                        end
                        n.meta_type = mt;
                        if (vlq_new == 28'd0) begin
                            n.phase = PH_DELTA;
                            if (mt == META_END) begin
                                vld = 1'b1;
                                kind = KIND_END;
                                n.ignored = 1'b1;
                            end else if (mt == META_TEMPO) begin
                                vld = 1'b1;
                                kind = KIND_TEMPO;
                                r_tempo = s.tempo;
                            end
                        end else begin
                            n.left = vlq_new;
                            n.phase = PH_META_BODY;
                        end
                    end
                end
                PH_META_BODY: begin
                    if (s.meta_type == META_TEMPO) begin
                        n.tempo = {s.tempo[15:0], b};
                    end
                    n.left = s.left - 28'd1;
                    if (n.left == 28'd0) begin
                        n.phase = PH_DELTA;
                        if (s.meta_type == META_END) begin
                            vld = 1'b1;
                            kind = KIND_END;
                            n.ignored = 1'b1;
                        end else if (s.meta_type == META_TEMPO) begin
                            vld = 1'b1;
                            kind = KIND_TEMPO;
                            r_tempo = n.tempo;
                        end
                    end
                end
                PH_SYSEX_LEN: begin
                    n.vlq = vlq_new;
                    n.vlq_cnt = vlq_done ? 3'd0 : cnt_inc;
                    if (vlq_bad) begin
                        vld = 1'b1;
                        kind = KIND_MALFORMED;
                        n.ignored = 1'b1;
                    end else if (vlq_done) begin
                        if (vlq_new == 28'd0) begin
                            n.run_status = 8'd0;
                            n.phase = PH_DELTA;
                        end else begin
                            n.left = vlq_new;
                            n.phase = PH_SYSEX_BODY;
                        end
                    end
                end
                PH_SYSEX_BODY: begin
                    n.left = s.left - 28'd1;
                    if (n.left == 28'd0) begin
                        n.run_status = 8'd0;
                        n.phase = PH_DELTA;
                    end
                end
                default: begin
                    n.phase = PH_DELTA;
                    n.vlq = vlq_new;
                    n.vlq_cnt = vlq_done ? 3'd0 : cnt_inc;
                    if (vlq_bad) begin
                        vld = 1'b1;
                        kind = KIND_MALFORMED;
                        n.ignored = 1'b1;
                    end else if (vlq_done) begin
                        n.tick = s.tick + {4'd0, vlq_new};
                        n.phase = PH_STATUS;
                    end
                end
            endcase
        end

        if (item_i.last_of_track) begin
            if (!s.ignored && !vld && (n.phase != PH_DELTA || n.vlq_cnt != 3'd0)) begin
                vld = 1'b1;
                kind = KIND_MALFORMED;
            end
            n.ignored = 1'b1;
        end

        if (kind != KIND_CHANNEL) begin
            r_st = '0;
            r_d1 = '0;
            r_d2 = '0;
        end
        if (kind != KIND_TEMPO) begin
            r_tempo = '0;
        end
    end

    assign state_o = n;
    assign res_vld_o = vld;
    assign res_o = '{event_kind: kind, event_tick: n.tick, message_status: r_st,
                     message_data1: r_d1, message_data2: r_d2, tempo_micros: r_tempo};

endmodule

// ===== hdl/smf_result_reg.sv =====
// Result register that holds one event until the downstream side takes it.
// Depends on smf_pkg for the result type.
module smf_result_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load_i,
    input  smf_pkg::result_t res_i,
    input  logic             take_i,
    output logic             vld_o,
    output smf_pkg::result_t res_o
);
    import smf_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    always_comb begin
        vld_next = vld_reg;
        if (load_i) begin
            vld_next = 1'b1;
        end else if (vld_reg && take_i) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            res_reg <= res_i;
        end
    end

    assign vld_o = vld_reg;
    assign res_o = res_reg;

endmodule

// ===== hdl/smf_track_event_parser_top.sv =====
// Path: an accepted byte is held in the input register; its event then loads into the result register behind m_tvalid.
// Throughput: one track byte per cycle while m_tready stays high; the result register
// lets the next byte enter while a finished event still waits.
// Reset: aresetn low at an edge empties the input and result registers and returns the parser
// to awaiting a delta time with a zero tick count and no running status.
`include "smf_track_event_parser_top_defines.svh"

module smf_track_event_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] track_byte
    input  logic [0:0]  s_tuser,   // [0] first_of_track
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] event_tick, [39:32] message_status, [47:40] message_data1,
    // [55:48] message_data2, [79:56] tempo_micros
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser    // [1:0] event_kind
);
    import smf_pkg::*;

    logic    in_vld_reg;
    logic    in_vld_next;
    item_t   in_item_reg;
    state_t  state_reg;
    state_t  state_next;
    state_t  step_state;
    logic    step_res_vld;
    result_t step_res;
    result_t out_res;
    logic    advance;
    logic    s_accept;
    logic    closing;
    logic    last_step;
    logic    vlq_ok;
    logic    blocked;

    assign advance = in_vld_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_accept) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        state_next = advance ? step_state : state_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            state_reg <= STATE_CLEAR;
        end else begin
            in_vld_reg <= in_vld_next;
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= '{track_byte: s_tdata, first_of_track: s_tuser[0],
                             last_of_track: s_tlast};
        end
    end

    smf_step u_step (
        .item_i    (in_item_reg),
        .state_i   (state_reg),
        .state_o   (step_state),
        .res_vld_o (step_res_vld),
        .res_o     (step_res)
    );

    smf_result_reg u_result (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load_i  (advance && step_res_vld),
        .res_i   (step_res),
        .take_i  (m_tready),
        .vld_o   (m_tvalid),
        .res_o   (out_res)
    );

    assign m_tdata = {out_res.tempo_micros, out_res.message_data2, out_res.message_data1,
                      out_res.message_status, out_res.event_tick};
    assign m_tuser = out_res.event_kind;

    assign closing = advance && step_res_vld &&
                     (step_res.event_kind == KIND_END || step_res.event_kind == KIND_MALFORMED);
    assign last_step = advance && in_item_reg.last_of_track;
    assign vlq_ok = state_reg.vlq_cnt < MAX_VLQ_BYTES;
    assign blocked = in_vld_reg && m_tvalid && !m_tready;

    `SMF_ASSERT_NEXT(a_end_ignores, closing, state_reg.ignored, "Parser active after closing.")
    `SMF_ASSERT_NEXT(a_last_ignores, last_step, state_reg.ignored, "Parser active after last.")
    `SMF_ASSERT_SAME(a_phase_legal, 1'b1, state_reg.phase <= PH_SYSEX_BODY, "Unused phase.")
    `SMF_ASSERT_SAME(a_vlq_bound, !state_reg.ignored, vlq_ok, "Length count out of range.")
    `SMF_ASSERT_SAME(a_stall_cause, !s_tready, blocked, "Input stalled with no blocked result.")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for smf_track_event_parser_top: feeds track chunk bodies byte by
// byte over the input stream and checks each event against a byte-level parser model.
// Depends on smf_pkg and the RTL of the block.
module testbench;
    import smf_pkg::*;

    typedef enum logic [1:0] {LEN_MORE, LEN_DONE, LEN_BAD} len_step_t;

    localparam int HOLD_CYCLES = 250;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [0:0]  s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;

    item_t      byte_feed[$];
    result_t    awaited_events[$];
    logic [7:0] track_body[$];
    logic [7:0] gen_run_st;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    bit         hold_req = 1'b0;
    bit         hold_used;
    int         hold_left;
    int         mismatch_count = 0;

    logic [3:0]  trk_phase;
    logic [31:0] trk_tick;
    logic [27:0] len_acc;
    logic [2:0]  len_cnt;
    logic [7:0]  run_st;
    logic [7:0]  cur_st;
    logic [7:0]  held_d1;
    logic [7:0]  meta_kind;
    logic [27:0] bytes_left;
    logic [23:0] tempo_acc;
    bit          track_closed;

    smf_track_event_parser_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic void clear_track();
        trk_phase    = PH_DELTA;
        trk_tick     = '0;
        len_acc      = '0;
        len_cnt      = '0;
        run_st       = '0;
        cur_st       = '0;
        held_d1      = '0;
        meta_kind    = '0;
        bytes_left   = '0;
        tempo_acc    = '0;
        track_closed = 1'b0;
    endfunction

    function automatic bit two_data(input logic [7:0] st);
        return st[7:4] != HI_PROGRAM && st[7:4] != HI_PRESSURE;
    endfunction

    function automatic result_t make_event(input logic [1:0] kind, input logic [7:0] st,
                                           input logic [7:0] d1, input logic [7:0] d2,
                                           input logic [23:0] tempo);
        result_t r;
        r.event_kind     = kind;
        r.event_tick     = trk_tick;
        r.message_status = st;
        r.message_data1  = d1;
        r.message_data2  = d2;
        r.tempo_micros   = tempo;
        return r;
    endfunction

    function automatic result_t malformed_event();
        track_closed = 1'b1;
        return make_event(KIND_MALFORMED, 8'h00, 8'h00, 8'h00, 24'h0);
    endfunction

    function automatic len_step_t take_length(input logic [7:0] b);
        if (len_cnt == 0)
            len_acc = '0;
        len_acc = {len_acc[20:0], b[6:0]};
        len_cnt = len_cnt + 3'd1;
        if (!b[7]) begin
            len_cnt = '0;
            return LEN_DONE;
        end
        if (len_cnt >= MAX_VLQ_BYTES)
            return LEN_BAD;
        return LEN_MORE;
    endfunction

    function automatic bit close_meta(output result_t ev);
        trk_phase = PH_DELTA;
        ev = '0;
        if (meta_kind == META_END) begin
            ev = make_event(KIND_END, 8'h00, 8'h00, 8'h00, 24'h0);
            track_closed = 1'b1;
            return 1'b1;
        end
        if (meta_kind == META_TEMPO) begin
            ev = make_event(KIND_TEMPO, 8'h00, 8'h00, 8'h00, tempo_acc);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the parser model by one accepted byte; returns 1 when the byte yields an event.
    function automatic bit parse_byte(input logic [7:0] b, input bit is_first, input bit is_last,
                                      output result_t ev);
        bit        hit;
        len_step_t ls;
        hit = 1'b0;
        ev = '0;
        if (is_first)
            clear_track();
        if (!track_closed) begin
            case (trk_phase)
                PH_STATUS: begin
                    if (b == BYTE_META) begin
                        trk_phase = PH_META_TYPE;
                    end else if (b == BYTE_SYSEX || b == BYTE_SYSEX_ESC) begin
                        trk_phase = PH_SYSEX_LEN;
                    end else if (!b[7]) begin
                        if (run_st == 0) begin
                            ev = malformed_event();
                            hit = 1'b1;
                        end else begin
                            cur_st = run_st;
                            held_d1 = b;
                            if (two_data(cur_st)) begin
                                trk_phase = PH_DATA2;
                            end else begin
                                ev = make_event(KIND_CHANNEL, cur_st, b, 8'h00, 24'h0);
                                trk_phase = PH_DELTA;
                                hit = 1'b1;
                            end
                        end
                    end else begin
                        run_st = b;
                        cur_st = b;
                        trk_phase = PH_DATA1;
                    end
                end
                PH_DATA1: begin
                    held_d1 = b;
                    if (two_data(cur_st)) begin
                        trk_phase = PH_DATA2;
                    end else begin
                        ev = make_event(KIND_CHANNEL, cur_st, b, 8'h00, 24'h0);
                        trk_phase = PH_DELTA;
                        hit = 1'b1;
                    end
                end
                PH_DATA2: begin
                    ev = make_event(KIND_CHANNEL, cur_st, held_d1, b, 24'h0);
                    trk_phase = PH_DELTA;
                    hit = 1'b1;
                end
                PH_META_TYPE: begin
                    meta_kind = b;
                    tempo_acc = '0;
                    trk_phase = PH_META_LEN;
                end
                PH_META_LEN: begin
                    ls = take_length(b);
                    if (ls == LEN_BAD) begin
                        ev = malformed_event();
                        hit = 1'b1;
                    end else if (ls == LEN_DONE) begin
                        if (meta_kind == META_TEMPO && len_acc != 28'd3)
                            meta_kind = '0;
                        if (len_acc == 0) begin
                            hit = close_meta(ev);
                        end else begin
                            bytes_left = len_acc;
                            trk_phase = PH_META_BODY;
                        end
                    end
                end
                PH_META_BODY: begin
                    if (meta_kind == META_TEMPO)
                        tempo_acc = {tempo_acc[15:0], b};
                    bytes_left = bytes_left - 28'd1;
                    if (bytes_left == 0)
                        hit = close_meta(ev);
                end
                PH_SYSEX_LEN: begin
                    ls = take_length(b);
                    if (ls == LEN_BAD) begin
                        ev = malformed_event();
                        hit = 1'b1;
                    end else if (ls == LEN_DONE) begin
                        if (len_acc == 0) begin
                            run_st = '0;
                            trk_phase = PH_DELTA;
                        end else begin
                            bytes_left = len_acc;
                            trk_phase = PH_SYSEX_BODY;
                        end
                    end
                end
                PH_SYSEX_BODY: begin
                    bytes_left = bytes_left - 28'd1;
                    if (bytes_left == 0) begin
                        run_st = '0;
                        trk_phase = PH_DELTA;
                    end
                end
                default: begin
                    trk_phase = PH_DELTA;
                    ls = take_length(b);
                    if (ls == LEN_BAD) begin
                        ev = malformed_event();
                        hit = 1'b1;
                    end else if (ls == LEN_DONE) begin
                        trk_tick = trk_tick + {4'h0, len_acc};
                        trk_phase = PH_STATUS;
                    end
                end
            endcase
        end
        if (is_last) begin
            if (!track_closed && !hit && (trk_phase != PH_DELTA || len_cnt != 0)) begin
                ev = malformed_event();
                hit = 1'b1;
            end
            track_closed = 1'b1;
        end
        return hit;
    endfunction

    function automatic logic [7:0] data_byte();
        if ($urandom_range(5) == 0)
            return 8'($urandom_range(255));
        return 8'($urandom_range(127));
    endfunction

    task automatic add_byte(input logic [7:0] b);
        track_body.insert(track_body.size(), b);
    endtask

    task automatic push_item(input logic [7:0] b, input bit is_first, input bit is_last);
        item_t it;
        it.track_byte     = b;
        it.first_of_track = is_first;
        it.last_of_track  = is_last;
        byte_feed.insert(byte_feed.size(), it);
    endtask

    task automatic commit_track();
        int k;
        for (k = 0; k < track_body.size(); k++)
            push_item(track_body[k], k == 0, k == track_body.size() - 1);
        track_body.delete();
    endtask

    task automatic add_delta(input int nbytes, input bit top_heavy);
        int         k;
        logic [6:0] grp;
        for (k = 0; k < nbytes; k++) begin
            grp = (top_heavy && k == 0) ? 7'h7F : 7'($urandom_range(127));
            add_byte({k != nbytes - 1, grp});
        end
    endtask

    task automatic add_length(input int len);
        if ($urandom_range(3) == 0)
            add_byte(8'h80);
        if (len >= 128)
            add_byte({1'b1, len[13:7]});
        add_byte({1'b0, len[6:0]});
    endtask

    task automatic add_event();
        int         pick;
        int         len;
        logic [7:0] st;
        logic [7:0] mtype;
        pick = $urandom_range(99);
        if (pick < 55) begin
            if (gen_run_st != 0 && $urandom_range(2) == 0) begin
                add_byte(8'($urandom_range(127)));
                if (two_data(gen_run_st))
                    add_byte(data_byte());
            end else begin
                do begin
                    if ($urandom_range(9) == 0)
                        st = 8'($urandom_range(8'hFE, 8'hF1));
                    else
                        st = 8'($urandom_range(8'hEF, 8'h80));
                end while (st == BYTE_SYSEX_ESC);
                add_byte(st);
                add_byte(data_byte());
                if (two_data(st))
                    add_byte(data_byte());
                gen_run_st = st;
            end
        end else if (pick < 70) begin
            add_byte($urandom_range(1) ? BYTE_SYSEX : BYTE_SYSEX_ESC);
            len = ($urandom_range(24) == 0) ? $urandom_range(140, 128) : $urandom_range(6);
            add_length(len);
            repeat (len) add_byte(8'($urandom_range(255)));
            gen_run_st = 8'h00;
        end else begin
            add_byte(BYTE_META);
            if (pick < 85) begin
                mtype = META_TEMPO;
                len = ($urandom_range(3) == 0) ? $urandom_range(5) : 3;
            end else begin
                do mtype = 8'($urandom_range(255));
                while (mtype == META_END || mtype == META_TEMPO);
                len = $urandom_range(8);
            end
            add_byte(mtype);
            add_length(len);
            repeat (len) add_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic add_directed();
        logic [7:0] seq_a [21] = '{8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hC5, 8'hFF,
                                   8'h00, 8'h9F, 8'h80, 8'hFF,
                                   8'h00, BYTE_META, META_TEMPO, 8'h03, 8'h07, 8'hA1, 8'h20,
                                   8'h00, BYTE_META, META_END, 8'h00};
        foreach (seq_a[k])
            add_byte(seq_a[k]);
        commit_track();
        // A one-byte track stops after its delta time, before any status byte.
        add_byte(8'h00);
        commit_track();
        // A data byte before any status byte.
        add_byte(8'h00);
        add_byte(8'h40);
        commit_track();
    endtask

    task automatic fill_random(input int target);
        int made;
        int flavor;
        int n_ev;
        int k;
        int cut;
        made = 0;
        while (made < target) begin
            track_body.delete();
            gen_run_st = 8'h00;
            flavor = $urandom_range(99);
            if (flavor < 4) begin
                repeat ($urandom_range(12, 1)) begin
                    push_item(8'($urandom_range(255)), $urandom_range(3) == 0,
                              $urandom_range(3) == 0);
                    made++;
                end
            end else begin
                if (flavor < 9) begin
                    add_delta(1, 1'b0);
                    add_byte(8'($urandom_range(127)));
                end else begin
                    n_ev = (flavor >= 95) ? 18 : $urandom_range(10, 1);
                    for (k = 0; k < n_ev; k++) begin
                        if (flavor >= 95)
                            add_delta(4, 1'b1);
                        else
                            add_delta(($urandom_range(4) == 0) ? $urandom_range(4, 2) : 1, 1'b0);
                        add_event();
                    end
                    if (flavor < 17) begin
                        // Length or delta with too many continuation bytes.
                        case ($urandom_range(2))
                            0: ;
                            1: begin
                                add_delta(1, 1'b0);
                                add_byte(BYTE_SYSEX);
                            end
                            default: begin
                                add_delta(1, 1'b0);
                                add_byte(BYTE_META);
                                add_byte(8'($urandom_range(127)));
                            end
                        endcase
                        repeat (4) add_byte(8'h80 | 8'($urandom_range(127)));
                    end else if (flavor >= 33) begin
                        add_delta(1, 1'b0);
                        add_byte(BYTE_META);
                        add_byte(META_END);
                        k = ($urandom_range(5) == 0) ? $urandom_range(2, 1) : 0;
                        add_length(k);
                        repeat (k) add_byte(8'($urandom_range(255)));
                        if (flavor < 40)
                            repeat ($urandom_range(4, 1))
                                add_byte(8'($urandom_range(255)));
                    end
                    if (flavor >= 17 && flavor < 27) begin
                        cut = $urandom_range(track_body.size() - 1, 1);
                        while (track_body.size() > cut)
                            void'(track_body.pop_back());
                    end
                end
                made += track_body.size();
                commit_track();
            end
        end
    endtask

    task automatic wait_fed();
        while (byte_feed.size() != 0 || s_tvalid)
            @(negedge aclk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : feed_proc
        result_t ev;
        item_t   nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (parse_byte(s_tdata, s_tuser[0], s_tlast, ev))
                    awaited_events.insert(awaited_events.size(), ev);
            end
            if (!s_tvalid || s_tready) begin
                if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = byte_feed.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.track_byte;
                    s_tuser  <= nxt.first_of_track;
                    s_tlast  <= nxt.last_of_track;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // The receiver holds off once for a long stretch so that the block backs up its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_req && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : event_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_events.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual kind %0h data %h",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = awaited_events.pop_front();
                check_field("event_kind", 32'(want.event_kind), 32'(m_tuser));
                check_field("event_tick", want.event_tick, m_tdata[31:0]);
                check_field("message_status", 32'(want.message_status), 32'(m_tdata[39:32]));
                check_field("message_data1", 32'(want.message_data1), 32'(m_tdata[47:40]));
                check_field("message_data2", 32'(want.message_data2), 32'(m_tdata[55:48]));
                check_field("tempo_micros", 32'(want.tempo_micros), 32'(m_tdata[79:56]));
            end
        end
    end

    initial begin : stimulus
        int phase_no;
        int drain;
        clear_track();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        add_directed();
        wait_fed();
        for (phase_no = 0; phase_no < 4; phase_no++) begin
            case (phase_no)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                    hold_req = 1'b1;
                end
                1: begin
                    send_idle_pct = 75;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 75;
                end
                default: begin
                    send_idle_pct = 37;
                    stall_pct = 37;
                end
            endcase
            fill_random(340);
            wait_fed();
        end
        send_idle_pct = 0;
        stall_pct = 0;
        drain = 0;
        while (awaited_events.size() != 0 && drain < 2000) begin
            @(negedge aclk);
            drain++;
        end
        repeat (10) @(negedge aclk);
        if (awaited_events.size() != 0) begin
            $display("%0t: %0d expected events never arrived", $time, awaited_events.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
